>>> hdl/lpw_pkg.sv
// ----------------------------------------------------------------------------
// Lossy pipe waveguide package
// Shared constants, register indices, state encoding and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lpw_pkg;

	localparam int unsigned MAX_DELAY_DEF    = 256;
	localparam int unsigned SAMPLE_WIDTH_DEF = 24;

	localparam int unsigned MIN_DELAY  = 4;
	localparam int unsigned OPEN_POLE  = 7373;
	localparam int unsigned COEF_FRAC  = 14;
	localparam int unsigned ROUND_HALF = 8192;
	localparam int unsigned COEF_ONE   = 16384;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;
	localparam int unsigned DLEN_W     = 9;
	localparam int unsigned COEF_W     = 15;

	localparam logic [DLEN_W-1:0] DLEN_RST  = 9'd64;
	localparam logic [COEF_W-1:0] OREF_RST  = 15'h6666;
	localparam logic [COEF_W-1:0] CREF_RST  = 15'd8520;
	localparam logic [COEF_W-1:0] WDAMP_RST = 15'd6881;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH   = 2'd0,
		REG_OPEN_REFLECT   = 2'd1,
		REG_CLOSED_REFLECT = 2'd2,
		REG_WALL_DAMPING   = 2'd3
	} lpw_reg_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_MUL1  = 6'b000100,
		ST_ADD1  = 6'b001000,
		ST_MUL2  = 6'b010000,
		ST_FIN   = 6'b100000
	} lpw_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic mul1;
		logic add1;
		logic mul2;
		logic fin;
	} lpw_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} lpw_sts_t;

endpackage

>>> hdl/lossy_pipe_waveguide.sv
// ----------------------------------------------------------------------------
// Lossy pipe waveguide
// Two-way digital waveguide pipe model with lossy open and closed ends.
// ----------------------------------------------------------------------------
// Sequence: after its input transfer a sample passes MUL1, ADD1, MUL2 and FIN,
// which waits while the previous result is stalled at the output. A new sample
// is taken only in IDLE, after the line read, two dependent multiply and round
// steps through the filters and the return to idle.
// Reset: filters, position and out_valid clear at once, config takes reset values;
// a clearing pass then zeroes both delay lines while in_stall stays high.
module lossy_pipe_waveguide #(
	parameter int unsigned MAX_DELAY    = lpw_pkg::MAX_DELAY_DEF,
	parameter int unsigned SAMPLE_WIDTH = lpw_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] out_sample,
	output logic                           clipped
);

	import lpw_pkg::*;

	lpw_cmd_t cmd;
	lpw_sts_t sts;

	lpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpw_dpath #(
		.MAX_DELAY    (MAX_DELAY),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.clipped    (clipped),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> hdl/lpw_ram.sv
// ----------------------------------------------------------------------------
// Lossy pipe waveguide RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module lpw_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/lpw_ctrl.sv
// ----------------------------------------------------------------------------
// Lossy pipe waveguide controller
// Sequences the clearing pass after reset and the steps of one sample.
// ----------------------------------------------------------------------------
module lpw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lpw_pkg::lpw_sts_t sts,
	output lpw_pkg::lpw_cmd_t cmd
);

	import lpw_pkg::*;

	lpw_state_t st_q;
	lpw_state_t st_d;

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		unique case (st_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					st_d       = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				st_d     = ST_ADD1;
			end
			ST_ADD1: begin
				cmd.add1 = 1'b1;
				st_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				st_d     = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	assign in_stall = (st_q != ST_IDLE);

endmodule

>>> hdl/lpw_dpath.sv
// ----------------------------------------------------------------------------
// Lossy pipe waveguide datapath
// Configuration registers, the two delay lines, both lowpass filters, the
// reflection products and the output register.
// ----------------------------------------------------------------------------
module lpw_dpath #(
	parameter int unsigned MAX_DELAY    = lpw_pkg::MAX_DELAY_DEF,
	parameter int unsigned SAMPLE_WIDTH = lpw_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0]    in_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]    out_sample,
	output logic                              clipped,
	input  lpw_pkg::lpw_cmd_t                 cmd,
	output lpw_pkg::lpw_sts_t                 sts
);

	import lpw_pkg::*;

	localparam int unsigned SW = SAMPLE_WIDTH;
	localparam int unsigned PW = SAMPLE_WIDTH + 17;
	localparam int unsigned AW = $clog2(MAX_DELAY);
	localparam int unsigned LW = ((AW + 1) > DLEN_W) ? (AW + 1) : DLEN_W;
	localparam logic signed [15:0] POLE_S = 16'(OPEN_POLE);

	function automatic logic [SW:0] sat_fn(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = $signed({{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return {1'b1, hi[SW-1:0]};
		end else if (v < lo) begin
			return {1'b1, lo[SW-1:0]};
		end
		return {1'b0, v[SW-1:0]};
	endfunction

	function automatic logic signed [PW-1:0] rnd_fn(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v + PW'(ROUND_HALF);
		return t >>> COEF_FRAC;
	endfunction

	logic [DLEN_W-1:0] cfg_len_q;
	logic [COEF_W-1:0] cfg_oref_q;
	logic [COEF_W-1:0] cfg_cref_q;
	logic [COEF_W-1:0] cfg_wd_q;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] clr_q;
	logic [LW-1:0] len_eff;
	logic [LW-1:0] pos_nxt;
	logic [AW-1:0] pos_eff;

	logic signed [SW-1:0] olp_q;
	logic signed [SW-1:0] wlp_q;
	logic signed [SW-1:0] x_q;
	logic signed [SW-1:0] a_q;
	logic signed [PW-1:0] po_q;
	logic signed [PW-1:0] pw_q;
	logic signed [PW-1:0] pr_q;
	logic signed [PW-1:0] pf_q;
	logic                 clip_q;
	logic                 out_valid_q;

	logic [SW-1:0]        fwd_rdata;
	logic [SW-1:0]        bwd_rdata;
	logic signed [SW-1:0] a_w;
	logic signed [SW-1:0] b_w;
	logic signed [SW:0]   d_o;
	logic signed [SW:0]   d_w;
	logic [COEF_W-1:0]    wd_c;
	logic signed [15:0]   wd_s;
	logic [SW:0]          olp_n;
	logic [SW:0]          wlp_n;
	logic [SW:0]          r_n;
	logic [SW:0]          fb_n;
	logic [SW:0]          fwd_n;
	logic [SW:0]          y_n;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SW-1:0]        fwd_wdata;
	logic [SW-1:0]        bwd_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q  <= DLEN_RST;
			cfg_oref_q <= OREF_RST;
			cfg_cref_q <= CREF_RST;
			cfg_wd_q   <= WDAMP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELAY_LENGTH:   cfg_len_q  <= cfg_data[DLEN_W-1:0];
				REG_OPEN_REFLECT:   cfg_oref_q <= cfg_data[COEF_W-1:0];
				REG_CLOSED_REFLECT: cfg_cref_q <= cfg_data[COEF_W-1:0];
				REG_WALL_DAMPING:   cfg_wd_q   <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (LW'(cfg_len_q) < LW'(MIN_DELAY)) begin
			len_eff = LW'(MIN_DELAY);
		end else if (LW'(cfg_len_q) > LW'(MAX_DELAY)) begin
			len_eff = LW'(MAX_DELAY);
		end else begin
			len_eff = LW'(cfg_len_q);
		end
	end

	assign pos_eff = (LW'(pos_q) >= len_eff) ? '0 : pos_q;
	assign pos_nxt = LW'(addr_q) + LW'(1);

	assign wd_c = (cfg_wd_q > COEF_W'(COEF_ONE)) ? COEF_W'(COEF_ONE) : cfg_wd_q;
	assign wd_s = $signed({1'b0, wd_c});

	assign a_w = $signed(fwd_rdata);
	assign b_w = $signed(bwd_rdata);
	assign d_o = (SW+1)'(a_w) - (SW+1)'(olp_q);
	assign d_w = (SW+1)'(b_w) - (SW+1)'(wlp_q);

	assign olp_n = sat_fn(PW'(olp_q) + rnd_fn(po_q));
	assign wlp_n = sat_fn(PW'(wlp_q) + rnd_fn(pw_q));
	assign r_n   = sat_fn(rnd_fn(pr_q));
	assign fb_n  = sat_fn(rnd_fn(pf_q));
	assign fwd_n = sat_fn(PW'(x_q) + PW'($signed(fb_n[SW-1:0])));
	assign y_n   = sat_fn(PW'(a_q) - PW'($signed(r_n[SW-1:0])));

	assign ram_we    = cmd.clear || cmd.fin;
	assign ram_waddr = cmd.clear ? clr_q : addr_q;
	assign fwd_wdata = cmd.clear ? '0 : fwd_n[SW-1:0];
	assign bwd_wdata = cmd.clear ? '0 : r_n[SW-1:0];

	lpw_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_DELAY)
	) u_fwd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (fwd_wdata),
		.raddr (pos_eff),
		.rdata (fwd_rdata)
	);

	lpw_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_DELAY)
	) u_bwd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (bwd_wdata),
		.raddr (pos_eff),
		.rdata (bwd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			pos_q       <= '0;
			olp_q       <= '0;
			wlp_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.accept) begin
				clip_q <= 1'b0;
			end
			if (cmd.add1) begin
				olp_q  <= $signed(olp_n[SW-1:0]);
				wlp_q  <= $signed(wlp_n[SW-1:0]);
				clip_q <= clip_q | olp_n[SW] | wlp_n[SW];
			end
			if (cmd.fin) begin
				pos_q       <= (pos_nxt >= len_eff) ? '0 : pos_nxt[AW-1:0];
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q    <= in_sample;
			addr_q <= pos_eff;
		end
		if (cmd.mul1) begin
			a_q  <= a_w;
			po_q <= PW'(d_o) * PW'(POLE_S);
			pw_q <= PW'(d_w) * PW'(wd_s);
		end
		if (cmd.mul2) begin
			pr_q <= PW'(olp_q) * PW'($signed(cfg_oref_q));
			pf_q <= PW'(wlp_q) * PW'($signed(cfg_cref_q));
		end
		if (cmd.fin) begin
			out_sample <= $signed(y_n[SW-1:0]);
			clipped    <= clip_q | r_n[SW] | fb_n[SW] | fwd_n[SW] | y_n[SW];
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.clear_last = (clr_q == AW'(MAX_DELAY - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	a_fin_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q)
		else $error("A finished sample did not raise the output valid.");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.fin))
		else $error("Output valid rose without a finished sample.");

	a_addr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (LW'(addr_q) < $past(len_eff)))
		else $error("Line address lies beyond the effective delay length.");

endmodule
